@@ hw/rtl/cdq_pkg.sv @@
package cdq_pkg;

  localparam int unsigned DepthDefault = 16;
  localparam int unsigned WordWidth = 32;
  localparam int unsigned OccWidth = 5;

  typedef enum logic [1:0] {
    KindPushFront = 2'd0,
    KindPushRear  = 2'd1,
    KindPopFront  = 2'd2,
    KindPopRear   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    StDone  = 2'd0,
    StFull  = 2'd1,
    StEmpty = 2'd2
  } status_e;

  typedef logic signed [WordWidth-1:0] word_t;

  typedef struct packed {
    logic start;
    logic fetch;
  } cdq_cmd_t;

  typedef struct packed {
    logic need_fetch;
  } cdq_sts_t;

endpackage

@@ hw/rtl/cdq_if.sv @@
interface cdq_in_if;
  import cdq_pkg::*;

  logic  valid;
  logic  ready;
  kind_e kind;
  word_t value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface cdq_out_if;
  import cdq_pkg::*;

  logic                valid;
  logic                ready;
  word_t               popped_value;
  status_e             status;
  word_t               front_value;
  word_t               rear_value;
  logic [OccWidth-1:0] occupancy;

  modport source (
    output valid, output popped_value, output status, output front_value,
    output rear_value, output occupancy, input ready
  );
  modport sink (
    input valid, input popped_value, input status, input front_value,
    input rear_value, input occupancy, output ready
  );
endinterface

@@ hw/rtl/cdq_dp.sv @@
module cdq_dp #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault,
  localparam int unsigned PW = $clog2(DEPTH),
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  cdq_pkg::cdq_cmd_t             cmd_i,
  output cdq_pkg::cdq_sts_t             sts_o,
  input  cdq_pkg::kind_e                kind_i,
  input  cdq_pkg::word_t                value_i,
  output cdq_pkg::word_t                popped_value_o,
  output cdq_pkg::status_e              status_o,
  output cdq_pkg::word_t                front_value_o,
  output cdq_pkg::word_t                rear_value_o,
  output logic [cdq_pkg::OccWidth-1:0]  occupancy_o,
  output logic [CW-1:0]                 count_o
);
  import cdq_pkg::*;

  word_t           mem [DEPTH];
  word_t           rd_data_q;
  logic   [PW-1:0] head_q, head_d, tail_q, tail_d;
  logic   [CW-1:0] count_q, count_d;
  word_t           front_q, front_d, rear_q, rear_d;
  word_t           popped_q, popped_d;
  status_e         status_q, status_d;
  logic            op_front_q, op_front_d;
  logic            mem_we;
  logic   [PW-1:0] mem_waddr, mem_raddr;
  logic   [PW-1:0] head_inc, head_dec, tail_inc, tail_dec;
  logic            full, empty, is_push;
  logic   [CW+OccWidth-1:0] occ_ext;

  assign head_inc = (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign head_dec = (head_q == '0) ? PW'(DEPTH - 1) : head_q - 1'b1;
  assign tail_inc = (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign tail_dec = (tail_q == '0) ? PW'(DEPTH - 1) : tail_q - 1'b1;

  assign full    = (count_q == CW'(DEPTH));
  assign empty   = (count_q == '0);
  assign is_push = (kind_i == KindPushFront) || (kind_i == KindPushRear);

  assign sts_o.need_fetch = !is_push && !empty;

  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    count_d    = count_q;
    front_d    = front_q;
    rear_d     = rear_q;
    popped_d   = popped_q;
    status_d   = status_q;
    op_front_d = op_front_q;
    mem_we     = 1'b0;
    mem_waddr  = head_dec;
    mem_raddr  = head_inc;
    if (cmd_i.start) begin
      popped_d   = '0;
      status_d   = StDone;
      op_front_d = (kind_i == KindPopFront);
      unique case (kind_i)
        KindPushFront: begin
          if (full) begin
            status_d = StFull;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            head_d    = head_dec;
            count_d   = count_q + 1'b1;
            front_d   = value_i;
            if (empty) begin
              rear_d = value_i;
            end
          end
        end
        KindPushRear: begin
          if (full) begin
            status_d = StFull;
          end else begin
            mem_we    = 1'b1;
            mem_waddr = tail_inc;
            tail_d    = tail_inc;
            count_d   = count_q + 1'b1;
            rear_d    = value_i;
            if (empty) begin
              front_d = value_i;
            end
          end
        end
        KindPopFront: begin
          mem_raddr = head_inc;
          if (empty) begin
            status_d = StEmpty;
          end else begin
            popped_d = front_q;
            head_d   = head_inc;
            count_d  = count_q - 1'b1;
          end
        end
        KindPopRear: begin
          mem_raddr = tail_dec;
          if (empty) begin
            status_d = StEmpty;
          end else begin
            popped_d = rear_q;
            tail_d   = tail_dec;
            count_d  = count_q - 1'b1;
          end
        end
        default: begin
          status_d = StDone;
        end
      endcase
    end
    if (cmd_i.fetch) begin
      if (op_front_q) begin
        front_d = rd_data_q;
      end else begin
        rear_d = rd_data_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= value_i;
    end
    rd_data_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q     <= '0;
      tail_q     <= PW'(DEPTH - 1);
      count_q    <= '0;
      status_q   <= StDone;
      op_front_q <= 1'b0;
    end else begin
      head_q     <= head_d;
      tail_q     <= tail_d;
      count_q    <= count_d;
      status_q   <= status_d;
      op_front_q <= op_front_d;
    end
  end

  always_ff @(posedge clk_i) begin
    front_q  <= front_d;
    rear_q   <= rear_d;
    popped_q <= popped_d;
  end

  assign occ_ext        = (CW + OccWidth)'(count_q);
  assign popped_value_o = popped_q;
  assign status_o       = status_q;
  assign front_value_o  = empty ? '0 : front_q;
  assign rear_value_o   = empty ? '0 : rear_q;
  assign occupancy_o    = occ_ext[OccWidth-1:0];
  assign count_o        = count_q;

endmodule

@@ hw/rtl/cdq_ctrl.sv @@
module cdq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cdq_pkg::cdq_sts_t sts_i,
  output cdq_pkg::cdq_cmd_t cmd_o
);
  import cdq_pkg::*;

  typedef enum logic [1:0] {
    StateIdle,
    StateFetch,
    StateResp
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;

  assign in_ready_o  = (state_q == StateIdle) || ((state_q == StateResp) && out_ready_i);
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  assign cmd_o.start = accept;
  assign cmd_o.fetch = (state_q == StateFetch);

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    unique case (state_q)
      StateIdle: begin
        if (accept) begin
          state_d     = sts_i.need_fetch ? StateFetch : StateResp;
          out_valid_d = !sts_i.need_fetch;
        end
      end
      StateFetch: begin
        state_d     = StateResp;
        out_valid_d = 1'b1;
      end
      StateResp: begin
        if (accept) begin
          state_d     = sts_i.need_fetch ? StateFetch : StateResp;
          out_valid_d = !sts_i.need_fetch;
        end else if (out_ready_i) begin
          state_d     = StateIdle;
          out_valid_d = 1'b0;
        end
      end
      default: begin
        state_d     = StateIdle;
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ hw/rtl/circular_deque.sv @@
// Double-ended queue of signed 32-bit words held in a ring of DEPTH entries.
// The in_i channel carries one operation per beat: push front, push rear,
// pop front or pop rear, with the word to push. The out_o channel returns one
// beat per operation with the popped word, a status code, the front and rear
// words after the operation and the occupancy.
// A push, or any rejected operation, yields its result in the cycle after the
// input beat is accepted. A successful pop passes through a fetch state before
// its result, because the new front or rear word comes from the single
// registered read port of the ring memory. While a result is taken in the same
// cycle, the next input beat is accepted too, so pushes run at one beat per
// cycle while the receiver takes each result; no beat is taken during a fetch.
// Reset empties the deque at once; no clearing pass is needed, since only
// written entries are ever shown. When the receiver stalls, the result beat
// holds and no new input beat is taken until the result is taken.
module circular_deque #(
  parameter int unsigned DEPTH = cdq_pkg::DepthDefault
) (
  input logic   clk_i,
  input logic   rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);
  import cdq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  cdq_cmd_t        cmd;
  cdq_sts_t        sts;
  logic   [CW-1:0] count;

  cdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .kind_i         (in_i.kind),
    .value_i        (in_i.value),
    .popped_value_o (out_o.popped_value),
    .status_o       (out_o.status),
    .front_value_o  (out_o.front_value),
    .rear_value_o   (out_o.rear_value),
    .occupancy_o    (out_o.occupancy),
    .count_o        (count)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(DEPTH))
    else $error("occupancy exceeds depth");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |-> (!out_o.valid || out_o.ready))
    else $error("input taken while a result is stalled");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == StFull) |-> (count == CW'(DEPTH)))
    else $error("full status with free entries");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.status == StEmpty) |-> (count == '0))
    else $error("empty status with held entries");

endmodule
